/* rtl/core/fctt_pkg.sv */
// ----------------------------------------------------------------------------
// fctt_pkg
// Shared types and constants for the four-channel timer tick unit.
// ----------------------------------------------------------------------------
package fctt_pkg;

  localparam int unsigned NUM_TIMERS  = 4;
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned SLOT_COUNT  = 4;

  localparam int unsigned SRC_W     = 2;
  localparam int unsigned CMP_VAL_W = 16;
  localparam int unsigned CNT_OUT_W = 16;
  localparam int unsigned IRQ_W     = SLOT_COUNT;
  localparam int unsigned CMP_W     = (COUNT_WIDTH > CMP_VAL_W) ? COUNT_WIDTH : CMP_VAL_W;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned IN_TDATA_W   = 8;
  localparam int unsigned RES_W        = IRQ_W + SLOT_COUNT * CNT_OUT_W;
  localparam int unsigned OUT_TDATA_W  = ((RES_W + 7) / 8) * 8;

  // mode register bit positions
  localparam int unsigned MODE_SEL_LSB = 0;
  localparam int unsigned MODE_ZR_BIT  = 6;
  localparam int unsigned MODE_EN_BIT  = 7;
  localparam int unsigned MODE_CIRQ_BIT = 8;
  localparam int unsigned MODE_OIRQ_BIT = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE_T0 = 3'd0,
    CFG_MODE_T1 = 3'd1,
    CFG_MODE_T2 = 3'd2,
    CFG_MODE_T3 = 3'd3,
    CFG_CMP_T0  = 3'd4,
    CFG_CMP_T1  = 3'd5,
    CFG_CMP_T2  = 3'd6,
    CFG_CMP_T3  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic             oirq;
    logic             cirq;
    logic             en;
    logic             zr;
    logic [SRC_W-1:0] sel;
  } mode_t;

  typedef struct packed {
    logic [SLOT_COUNT-1:0][CNT_OUT_W-1:0] counts;
    logic [IRQ_W-1:0]                     irq;
  } result_t;

endpackage

/* rtl/core/four_channel_timer_tick_unit.sv */
// ----------------------------------------------------------------------------
// four_channel_timer_tick_unit
// Four 16-bit timers advanced by clock-source tick requests.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one tick request per beat; tdata[1:0] names the source
//   (bus, bus/16, bus/256, hblank). Each enabled timer selecting that source
//   counts up by one; compare/overflow interrupts and zero-return apply.
//   m_axis returns one result per request: interrupt flags and all counts.
//   The cfg port writes mode (index 0..3) and compare (4..7) registers;
//   write only while no request is in flight.
// Timing:
//   Counts update in the accept cycle; the result goes to the output register
//   (or to the skid while it is held). One request per cycle while the skid
//   is empty; the only loop is the count register and single increment/compare.
//   A two-entry output buffer (output register plus skid) keeps tready high
//   while one result waits; tready drops only when both entries are full.
// Reset:
//   rst_ni clears counts, registers and the valid flags of both output entries.
// ----------------------------------------------------------------------------
module four_channel_timer_tick_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [fctt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [1:0] clock_source
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // irq_flags, count_timer0, count_timer1, count_timer2, count_timer3, zero pad
  output logic [fctt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [fctt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fctt_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  fctt_pkg::mode_t [fctt_pkg::SLOT_COUNT-1:0]                          mode_q;
  logic [fctt_pkg::SLOT_COUNT-1:0][fctt_pkg::CMP_VAL_W-1:0]            cmp_q;
  logic [fctt_pkg::SLOT_COUNT-1:0][fctt_pkg::COUNT_WIDTH-1:0]          count_q;
  logic [fctt_pkg::SLOT_COUNT-1:0][fctt_pkg::COUNT_WIDTH-1:0]          count_d;
  logic [fctt_pkg::SLOT_COUNT-1:0][fctt_pkg::CNT_OUT_W-1:0]            res_counts;

  logic [fctt_pkg::SRC_W-1:0] src;
  logic [fctt_pkg::IRQ_W-1:0] irq;
  fctt_pkg::result_t          res;

  fctt_pkg::result_t main_q, main_d, skid_q, skid_d;
  logic              main_vld_q, main_vld_d, skid_vld_q, skid_vld_d;
  logic              push, pop;

  assign src  = s_axis_tdata[fctt_pkg::SRC_W-1:0];
  assign push = s_axis_tvalid && s_axis_tready;
  assign pop  = main_vld_q && m_axis_tready;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
      cmp_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (fctt_pkg::cfg_idx_e'(cfg_idx_i))
        fctt_pkg::CFG_MODE_T0, fctt_pkg::CFG_MODE_T1,
        fctt_pkg::CFG_MODE_T2, fctt_pkg::CFG_MODE_T3: begin
          mode_q[cfg_idx_i[1:0]] <= '{
            oirq: cfg_wdata_i[fctt_pkg::MODE_OIRQ_BIT],
            cirq: cfg_wdata_i[fctt_pkg::MODE_CIRQ_BIT],
            en:   cfg_wdata_i[fctt_pkg::MODE_EN_BIT],
            zr:   cfg_wdata_i[fctt_pkg::MODE_ZR_BIT],
            sel:  cfg_wdata_i[fctt_pkg::MODE_SEL_LSB +: fctt_pkg::SRC_W]
          };
        end
        fctt_pkg::CFG_CMP_T0, fctt_pkg::CFG_CMP_T1,
        fctt_pkg::CFG_CMP_T2, fctt_pkg::CFG_CMP_T3: begin
          cmp_q[cfg_idx_i[1:0]] <= cfg_wdata_i[fctt_pkg::CMP_VAL_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // per-timer tick logic
  for (genvar i = 0; i < fctt_pkg::SLOT_COUNT; i++) begin : g_tmr
    if (i < fctt_pkg::NUM_TIMERS) begin : g_on
      logic                            hit, match, wrap;
      logic [fctt_pkg::COUNT_WIDTH-1:0] inc;

      assign hit   = mode_q[i].en && (mode_q[i].sel == src);
      assign inc   = count_q[i] + fctt_pkg::COUNT_WIDTH'(1);
      assign wrap  = (inc == '0);
      assign match = (fctt_pkg::CMP_W'(inc) == fctt_pkg::CMP_W'(cmp_q[i]));

      assign irq[i]     = hit && ((mode_q[i].cirq && match) || (mode_q[i].oirq && wrap));
      assign count_d[i] = !hit ? count_q[i] : ((mode_q[i].zr && match) ? '0 : inc);
      assign res_counts[i] = fctt_pkg::CNT_OUT_W'(count_d[i]);
    end else begin : g_off
      assign irq[i]        = 1'b0;
      assign count_d[i]    = '0;
      assign res_counts[i] = '0;
    end
  end
  assign res = '{counts: res_counts, irq: irq};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (push) begin
      count_q <= count_d;
    end
  end

  // output register plus skid entry
  always_comb begin
    main_d     = main_q;
    main_vld_d = main_vld_q;
    skid_d     = skid_q;
    skid_vld_d = skid_vld_q;
    if (pop) begin
      main_d     = skid_q;
      main_vld_d = skid_vld_q;
      skid_vld_d = 1'b0;
    end
    if (push) begin
      if (!main_vld_q || pop) begin
        main_d     = res;
        main_vld_d = 1'b1;
      end else begin
        skid_d     = res;
        skid_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign s_axis_tready = !skid_vld_q;
  assign m_axis_tvalid = main_vld_q;
  assign m_axis_tdata  = fctt_pkg::OUT_TDATA_W'(main_q);

  // assertions
  a_skid_implies_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> main_vld_q)
    else $error("skid entry held with empty output register");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !skid_vld_q && !push) |=> !main_vld_q)
    else $error("output valid after last result drained");

  a_idle_timer_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !(mode_q[0].en && (mode_q[0].sel == src))) |=> $stable(count_q[0]))
    else $error("timer 0 count moved on a tick it does not select");

  a_no_tick_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!push && !cfg_we_i) |=> $stable(count_q))
    else $error("counts changed without a tick request");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the four-channel timer tick unit. Tick requests go
// in on the input stream and a local model of the four timers predicts the
// interrupt flags and counts of every result. Directed checks cover reset
// state, every clock source, compare hits, zero-return, disabled timers and
// a long run of ticks on one source. Random phases then reprogram all
// registers between bursts. Both stream sides idle at random, with one long
// stall of the output side to fill the block.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned MODE_W       = 10;
  localparam int unsigned IDLE_PCT     = 25;
  localparam int unsigned LONG_TICKS   = 400;
  localparam int unsigned RANDOM_TICKS = 1330;
  localparam int unsigned MAX_PRINTS   = 50;

  typedef enum logic [fctt_pkg::SRC_W-1:0] {
    SRC_BUS    = 2'd0,
    SRC_BUS16  = 2'd1,
    SRC_BUS256 = 2'd2,
    SRC_HBLANK = 2'd3
  } clk_src_e;

  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [fctt_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // [1:0] clock_source
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  // irq_flags, count_timer0, count_timer1, count_timer2, count_timer3, zero pad
  logic [fctt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                             cfg_we_i      = 1'b0;
  logic [fctt_pkg::CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [fctt_pkg::CFG_DATA_W-1:0]  cfg_wdata_i   = '0;

  // timer model
  logic [MODE_W-1:0]                mode_q  [fctt_pkg::SLOT_COUNT];
  logic [fctt_pkg::CMP_VAL_W-1:0]   cmp_q   [fctt_pkg::SLOT_COUNT];
  logic [fctt_pkg::COUNT_WIDTH-1:0] count_q [fctt_pkg::SLOT_COUNT];
  fctt_pkg::result_t                pending_results [$];

  bit          no_idle     = 1'b0;
  bit          tx_burst    = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned cycle_count = 0;
  int unsigned n_ticks     = 0;
  int unsigned n_checked   = 0;
  int unsigned n_irq_seen  = 0;
  int unsigned n_cfg_wr    = 0;
  int unsigned n_errors    = 0;

  four_channel_timer_tick_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("** four_channel_timer_tick_unit: FAILED **");
      $finish;
    end
  end

  function automatic fctt_pkg::result_t advance_timers(clk_src_e src);
    fctt_pkg::result_t                res;
    logic [fctt_pkg::COUNT_WIDTH-1:0] nxt;
    logic                             hit;
    res = '0;
    for (int i = 0; i < fctt_pkg::NUM_TIMERS; i++) begin
      if (mode_q[i][fctt_pkg::MODE_EN_BIT] &&
          mode_q[i][fctt_pkg::MODE_SEL_LSB +: fctt_pkg::SRC_W] == src) begin
        nxt        = count_q[i] + 1'b1;
        hit        = (nxt == cmp_q[i]);
        count_q[i] = nxt;
        res.irq[i] = (mode_q[i][fctt_pkg::MODE_CIRQ_BIT] && hit) ||
                     (mode_q[i][fctt_pkg::MODE_OIRQ_BIT] && nxt == '0);
        if (mode_q[i][fctt_pkg::MODE_ZR_BIT] && hit) count_q[i] = '0;
      end
      res.counts[i] = count_q[i];
    end
    return res;
  endfunction

  // gate and spare bits are filled at random; the block ignores them
  function automatic logic [fctt_pkg::CFG_DATA_W-1:0] make_mode(clk_src_e sel, bit zr,
                                                                bit en, bit cirq,
                                                                bit oirq);
    logic [fctt_pkg::CFG_DATA_W-1:0] m;
    m = fctt_pkg::CFG_DATA_W'($urandom);
    m[fctt_pkg::MODE_SEL_LSB +: fctt_pkg::SRC_W] = sel;
    m[fctt_pkg::MODE_ZR_BIT]                     = zr;
    m[fctt_pkg::MODE_EN_BIT]                     = en;
    m[fctt_pkg::MODE_CIRQ_BIT]                   = cirq;
    m[fctt_pkg::MODE_OIRQ_BIT]                   = oirq;
    return m;
  endfunction

  task automatic report_mismatch(string what, logic [fctt_pkg::OUT_TDATA_W-1:0] got,
                                 logic [fctt_pkg::OUT_TDATA_W-1:0] want);
    if (n_errors < MAX_PRINTS)
      $display("mismatch @%0d result %0d: %s got %0h exp %0h", cycle_count, n_checked,
               what, got, want);
    n_errors++;
  endtask

  task automatic cfg_write(fctt_pkg::cfg_idx_e idx, logic [fctt_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx <= fctt_pkg::CFG_MODE_T3) mode_q[idx[1:0]] = val[MODE_W-1:0];
    else cmp_q[idx[1:0]] = val;
    n_cfg_wr++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_tick(clk_src_e src);
    @(negedge clk_i);
    while (!(no_idle || tx_burst) && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= fctt_pkg::IN_TDATA_W'(src);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(advance_timers(src));
    n_ticks++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // output side: random stalls, or a counted hold-off when requested
  always @(negedge clk_i) begin
    if (hold_cycles != 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else if (no_idle) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    fctt_pkg::result_t got;
    fctt_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = fctt_pkg::result_t'(m_axis_tdata[fctt_pkg::RES_W-1:0]);
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", m_axis_tdata, '0);
      end else begin
        want = pending_results.pop_front();
        if (got.irq !== want.irq)
          report_mismatch("irq_flags", fctt_pkg::OUT_TDATA_W'(got.irq),
                          fctt_pkg::OUT_TDATA_W'(want.irq));
        for (int i = 0; i < fctt_pkg::SLOT_COUNT; i++)
          if (got.counts[i] !== want.counts[i])
            report_mismatch($sformatf("count_timer%0d", i),
                            fctt_pkg::OUT_TDATA_W'(got.counts[i]),
                            fctt_pkg::OUT_TDATA_W'(want.counts[i]));
        if (m_axis_tdata[fctt_pkg::OUT_TDATA_W-1:fctt_pkg::RES_W] !== '0)
          report_mismatch("tdata pad",
            fctt_pkg::OUT_TDATA_W'(m_axis_tdata[fctt_pkg::OUT_TDATA_W-1:fctt_pkg::RES_W]),
            '0);
        if (want.irq != '0) n_irq_seen++;
        n_checked++;
      end
    end
  end

  task automatic test_after_reset();
    for (int s = 0; s < 4; s++) send_tick(clk_src_e'(s));
    drain();
  endtask

  task automatic test_directed();
    cfg_write(fctt_pkg::CFG_MODE_T0, make_mode(SRC_BUS, 1'b1, 1'b1, 1'b1, 1'b0));
    cfg_write(fctt_pkg::CFG_CMP_T0, 16'd2);
    cfg_write(fctt_pkg::CFG_MODE_T1, make_mode(SRC_BUS16, 1'b0, 1'b1, 1'b1, 1'b0));
    cfg_write(fctt_pkg::CFG_CMP_T1, 16'd3);
    cfg_write(fctt_pkg::CFG_MODE_T2, make_mode(SRC_BUS256, 1'b1, 1'b1, 1'b0, 1'b0));
    cfg_write(fctt_pkg::CFG_CMP_T2, 16'd1);
    cfg_write(fctt_pkg::CFG_MODE_T3, make_mode(SRC_HBLANK, 1'b0, 1'b0, 1'b1, 1'b1));
    cfg_write(fctt_pkg::CFG_CMP_T3, 16'd1);
    repeat (3) send_tick(SRC_BUS);
    repeat (4) send_tick(SRC_BUS16);
    repeat (2) send_tick(SRC_BUS256);
    repeat (2) send_tick(SRC_HBLANK);
    drain();
    // timer 3 now enabled, compare at the top value
    cfg_write(fctt_pkg::CFG_MODE_T3, make_mode(SRC_HBLANK, 1'b0, 1'b1, 1'b1, 1'b1));
    cfg_write(fctt_pkg::CFG_CMP_T3, 16'hFFFF);
    repeat (2) send_tick(SRC_HBLANK);
    send_tick(SRC_BUS);
    send_tick(SRC_BUS256);
    drain();
  endtask

  task automatic test_long_run();
    cfg_write(fctt_pkg::CFG_MODE_T0, make_mode(SRC_BUS, 1'b0, 1'b1, 1'b0, 1'b1));
    cfg_write(fctt_pkg::CFG_MODE_T1, make_mode(SRC_BUS, 1'b0, 1'b1, 1'b1, 1'b0));
    cfg_write(fctt_pkg::CFG_CMP_T1, 16'd150);
    cfg_write(fctt_pkg::CFG_MODE_T2, make_mode(SRC_BUS, 1'b1, 1'b1, 1'b1, 1'b0));
    cfg_write(fctt_pkg::CFG_CMP_T2, 16'd37);
    cfg_write(fctt_pkg::CFG_MODE_T3, make_mode(SRC_BUS, 1'b1, 1'b1, 1'b1, 1'b1));
    cfg_write(fctt_pkg::CFG_CMP_T3, 16'd250);
    for (int k = 0; k < LONG_TICKS; k++) begin
      no_idle = (k >= LONG_TICKS / 2);
      send_tick(SRC_BUS);
    end
    no_idle = 1'b0;
    drain();
  endtask

  task automatic test_backpressure();
    @(negedge clk_i);
    hold_cycles = 60;
    tx_burst    = 1'b1;
    repeat (40) send_tick(clk_src_e'($urandom_range(3)));
    tx_burst = 1'b0;
    drain();
  endtask

  task automatic program_random(int unsigned phase);
    logic [fctt_pkg::CFG_DATA_W-1:0] cmp;
    int unsigned                     pick;
    for (int i = 0; i < fctt_pkg::SLOT_COUNT; i++) begin
      if (phase == 0) begin
        cfg_write(fctt_pkg::cfg_idx_e'(i), '1);
        cfg_write(fctt_pkg::cfg_idx_e'(i + 4), '1);
      end else if (phase == 1) begin
        cfg_write(fctt_pkg::cfg_idx_e'(i), '0);
        cfg_write(fctt_pkg::cfg_idx_e'(i + 4), '0);
      end else begin
        cfg_write(fctt_pkg::cfg_idx_e'(i),
                  make_mode(clk_src_e'($urandom_range(3)), bit'($urandom_range(1)),
                            $urandom_range(99) < 85, $urandom_range(99) < 70,
                            bit'($urandom_range(1))));
        pick = $urandom_range(99);
        if (pick < 70) cmp = count_q[i] + fctt_pkg::CFG_DATA_W'($urandom_range(1, 24));
        else if (pick < 85) cmp = fctt_pkg::CFG_DATA_W'($urandom);
        else cmp = $urandom_range(1) ? '1 : '0;
        cfg_write(fctt_pkg::cfg_idx_e'(i + 4), cmp);
      end
    end
  endtask

  task automatic test_random();
    int unsigned phase;
    int unsigned len;
    int unsigned sent;
    phase = 0;
    sent  = 0;
    while (sent < RANDOM_TICKS) begin
      program_random(phase);
      len     = $urandom_range(40, 160);
      no_idle = (phase == 5);
      for (int k = 0; k < len; k++) send_tick(clk_src_e'($urandom_range(3)));
      sent += len;
      no_idle = 1'b0;
      drain();
      phase++;
    end
  endtask

  initial begin
    for (int i = 0; i < fctt_pkg::SLOT_COUNT; i++) begin
      mode_q[i]  = '0;
      cmp_q[i]   = '0;
      count_q[i] = '0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_after_reset();
    test_directed();
    test_long_run();
    test_backpressure();
    test_random();

    drain();
    repeat (10) @(posedge clk_i);
    $display("sent %0d tick requests, checked %0d results (%0d with interrupts), %0d reg writes",
             n_ticks, n_checked, n_irq_seen, n_cfg_wr);
    $display("covered all sources, compare irqs, zero-return, long runs, output stalls");
    if (n_errors == 0) begin
      $display("** four_channel_timer_tick_unit: PASSED **");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("** four_channel_timer_tick_unit: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/fctt_pkg.sv
rtl/core/four_channel_timer_tick_unit.sv
dv/tb_top.sv
